// ===== sv/mas_pkg.sv =====
// Shared types and constants for the matrix add/subtract/multiply unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package mas_pkg;

    localparam int DIM_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;
    localparam int DATA_W     = 32;

    // request codes
    localparam logic [1:0] REQ_WR_A = 2'd0;
    localparam logic [1:0] REQ_WR_B = 2'd1;
    localparam logic [1:0] REQ_RUN  = 2'd2;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [1:0]               row_index;
        logic [1:0]               col_index;
        logic signed [DATA_W-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               out_row;
        logic [1:0]               out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     status;
        logic                     last_flag;
    } out_item_t;

    // travels with each operand pair through the datapath pipeline
    typedef struct packed {
        logic       first;
        logic       last_k;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
        logic [1:0] op;
    } pipe_tag_t;

    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        logic      wr_sel_b;
        logic      err_load;
        pipe_tag_t tag;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/mas_dpath.sv =====
// Datapath: element stores A and B, read/compute/accumulate pipeline, output register.
// Depends on mas_pkg; driven by mas_ctrl.
`default_nettype none

module mas_dpath #(
    parameter int MAX_DIM = 4,
    parameter int AW      = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mas_pkg::dp_cmd_t      cmd,
    input  wire logic [AW-1:0]         rd_addr_a,
    input  wire logic [AW-1:0]         rd_addr_b,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [31:0]           wr_data,
    output mas_pkg::dp_status_t        status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mas_pkg::out_item_t         m_item
);
    import mas_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic              v1_reg, v2_reg;
    pipe_tag_t         tag1_reg, tag2_reg;
    logic [DATA_W-1:0] res2_reg, res2_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg;
    out_item_t         out_reg;
    logic              res_load;

    // stores: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !cmd.wr_sel_b) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (cmd.wr_en && cmd.wr_sel_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_a_reg <= mem_a[rd_addr_a];
            rd_b_reg <= mem_b[rd_addr_b];
        end
    end

    always_comb begin
        case (tag1_reg.op)
            OP_ADD:  res2_next = rd_a_reg + rd_b_reg;
            OP_SUB:  res2_next = rd_a_reg - rd_b_reg;
            default: res2_next = rd_a_reg * rd_b_reg;
        endcase
    end

    assign acc_next = tag2_reg.first ? res2_reg : acc_reg + res2_reg;
    assign res_load = v2_reg && tag2_reg.last_k;

    always_ff @(posedge aclk) begin
        tag1_reg <= cmd.tag;
        tag2_reg <= tag1_reg;
        res2_reg <= res2_next;
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
        if (res_load) begin
            out_reg.out_row   <= tag2_reg.row;
            out_reg.out_col   <= tag2_reg.col;
            out_reg.out_value <= acc_next;
            out_reg.status    <= 1'b0;
            out_reg.last_flag <= tag2_reg.last;
        end else if (cmd.err_load) begin
            out_reg.out_row   <= '0;
            out_reg.out_col   <= '0;
            out_reg.out_value <= '0;
            out_reg.status    <= 1'b1;
            out_reg.last_flag <= 1'b1;
        end
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            if (res_load || cmd.err_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.busy     = v1_reg || v2_reg;
    assign status.out_full = out_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_item          = out_reg;

    // a finished element never lands on a transaction still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    a_err_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.err_load |-> (!v1_reg && !v2_reg && !out_valid_reg))
        else $error("error result issued while pipeline busy");

    a_rd_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !cmd.wr_en)
        else $error("store read and write in the same cycle");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status) |-> m_item.last_flag)
        else $error("error result without last flag");

endmodule

`default_nettype wire

// ===== sv/mas_ctrl.sv =====
// Controller: configuration registers, shape check and run sequencer.
// Depends on mas_pkg; commands mas_dpath.
`default_nettype none

module mas_ctrl #(
    parameter int MAX_DIM = 4,
    parameter int AW      = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mas_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire mas_pkg::in_item_t                 s_item,
    input  wire mas_pkg::dp_status_t               status,
    output mas_pkg::dp_cmd_t                       cmd,
    output logic [AW-1:0]                          rd_addr_a,
    output logic [AW-1:0]                          rd_addr_b,
    output logic [AW-1:0]                          wr_addr
);
    import mas_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERR,
        ST_WAIT,
        ST_ISSUE
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [1:0]       op_mode_reg;
    logic [DIM_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;

    logic             accept, is_mul, shape_bad, slot_free, wr_in_grid;
    logic             last_k, last_col, last_elem;
    logic [DIM_W-1:0] out_cols, a_col, b_row;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (int'(d) <= MAX_DIM);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= OP_ADD;
            rows_a_reg  <= DIM_W'(1);
            cols_a_reg  <= DIM_W'(1);
            rows_b_reg  <= DIM_W'(1);
            cols_b_reg  <= DIM_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OP_MODE: op_mode_reg <= cfg_wdata[1:0];
                CFG_ROWS_A:  rows_a_reg  <= cfg_wdata;
                CFG_COLS_A:  cols_a_reg  <= cfg_wdata;
                CFG_ROWS_B:  rows_b_reg  <= cfg_wdata;
                CFG_COLS_B:  cols_b_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_mul    = (op_mode_reg == OP_MUL);
    assign out_cols  = is_mul ? cols_b_reg : cols_a_reg;
    assign shape_bad = (op_mode_reg != OP_ADD && op_mode_reg != OP_SUB && !is_mul)
                    || !dim_ok(rows_a_reg) || !dim_ok(cols_a_reg)
                    || !dim_ok(rows_b_reg) || !dim_ok(cols_b_reg)
                    || (is_mul ? (cols_a_reg != rows_b_reg)
                               : (rows_a_reg != rows_b_reg || cols_a_reg != cols_b_reg));
    assign slot_free = !status.busy && !status.out_full;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign wr_in_grid = (int'(s_item.row_index) < MAX_DIM)
                     && (int'(s_item.col_index) < MAX_DIM);

    assign last_k    = is_mul ? (k_reg + DIM_W'(1) == cols_a_reg) : 1'b1;
    assign last_col  = (j_reg + DIM_W'(1) == out_cols);
    assign last_elem = last_col && (i_reg + DIM_W'(1) == rows_a_reg);

    assign a_col = is_mul ? k_reg : j_reg;
    assign b_row = is_mul ? k_reg : i_reg;

    assign rd_addr_a = AW'(int'(i_reg) * MAX_DIM + int'(a_col));
    assign rd_addr_b = AW'(int'(b_row) * MAX_DIM + int'(j_reg));
    assign wr_addr   = AW'(int'(s_item.row_index) * MAX_DIM + int'(s_item.col_index));

    always_comb begin
        cmd            = '0;
        cmd.wr_en      = accept && wr_in_grid
                      && (s_item.req_type == REQ_WR_A || s_item.req_type == REQ_WR_B);
        cmd.wr_sel_b   = (s_item.req_type == REQ_WR_B);
        cmd.err_load   = (state_reg == ST_ERR) && slot_free;
        cmd.rd_en      = (state_reg == ST_ISSUE);
        cmd.tag.first  = (k_reg == '0);
        cmd.tag.last_k = last_k;
        cmd.tag.row    = i_reg[1:0];
        cmd.tag.col    = j_reg[1:0];
        cmd.tag.last   = last_elem;
        cmd.tag.op     = op_mode_reg;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_item.req_type == REQ_RUN) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = shape_bad ? ST_ERR : ST_WAIT;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT: begin
                // hold until the pipeline is empty and the previous element has left the output register
                if (slot_free) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (!last_k) begin
                    k_next = k_reg + DIM_W'(1);
                end else begin
                    k_next = '0;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                        if (last_col) begin
                            j_next = '0;
                            i_next = i_reg + DIM_W'(1);
                        end else begin
                            j_next = j_reg + DIM_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // an element is only issued into an empty pipeline with a free output slot
    a_issue_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && state_next == ST_ISSUE) |-> slot_free)
        else $error("element issued while pipeline or output busy");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE && is_mul) |-> (k_reg < cols_a_reg))
        else $error("inner index ran past cols_a");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (state_reg == ST_IDLE))
        else $error("store written outside idle");

endmodule

`default_nettype wire

// ===== sv/matrix_add_sub_mul_unit.sv =====
// Matrix add/subtract/multiply unit: controller and datapath.
// Load transactions are accepted only while idle. A run issues each element once the
// pipeline and output register are empty, so elements never overlap in the datapath;
// the one-pair-per-cycle read of the A and B stores sets the inner loop.
// A shape mismatch raises its error result from the error state once the output slot is free.
// aresetn (synchronous, active low) sets op_mode 0, all shapes 1; stores keep no reset.
`default_nettype none

module matrix_add_sub_mul_unit #(
    parameter int MAX_DIM = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mas_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire mas_pkg::in_item_t                 s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output mas_pkg::out_item_t                     m_item
);
    import mas_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;

    mas_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .status    (status),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr)
    );

    mas_dpath #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .wr_data   (s_item.elem_value),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
